### rtl/core/rmsa_pkg.sv
// Shared widths and command codes of the running mean and standard error accumulator.
package rmsa_pkg;

   localparam int SUM_BITS = 48;
   localparam int SQ_BITS  = 56;

   typedef enum logic [1:0] {
      CMD_ADD     = 2'd0,
      CMD_MERGE   = 2'd1,
      CMD_CLEAR   = 2'd2,
      CMD_REPLACE = 2'd3
   } cmd_type;

endpackage

### rtl/core/running_mean_stderr_accumulator.sv
// Top level: running count, mean and standard error accumulator with serial arithmetic.
//
// The req channel carries one command per transaction in req_tuser (add a sample, merge a
// summarised set, clear, replace with a set) and the operands in req_tdata. Every accepted
// transaction produces exactly one rsp transaction with the updated count, mean, standard
// error and the empty and sticky overflow flags.
// A new transaction is taken only once the previous one has moved its result into the output
// register. The time is set by the bit-serial multiplier (one multiplier bit per cycle), the
// shared restoring divider (one quotient bit per cycle, used for the mean, the mean square and
// the variance over the count) and the square root, one result bit per cycle.
// Reset clears the count, both sums and the overflow flag and empties the output register.
// When rsp_tready stays low the result holds in the output register; the block still takes one
// more req transaction and holds its finished result until the register frees up.
module running_mean_stderr_accumulator #(
   parameter  int SAMPLE_BITS = 24,
   parameter  int FRAC_BITS   = 12,
   parameter  int COUNT_BITS  = 20,
   localparam int REQ_BITS    = ((3 * SAMPLE_BITS + COUNT_BITS + 7) / 8) * 8,
   localparam int RSP_BITS    = ((2 * SAMPLE_BITS + COUNT_BITS + 7) / 8) * 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // sample, set_count, set_mean, set_stderr
   input  logic [REQ_BITS-1:0] req_tdata,
   // command
   input  logic [1:0]          req_tuser,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // paths_count, mean_value, std_error
   output logic [RSP_BITS-1:0] rsp_tdata,
   // empty_flag, overflow_flag
   output logic [1:0]          rsp_tuser
);

   localparam int SB  = SAMPLE_BITS;
   localparam int NW  = COUNT_BITS + 1;
   localparam int RB  = SAMPLE_BITS - 1;
   localparam int SUMW = rmsa_pkg::SUM_BITS;
   localparam int SQW = rmsa_pkg::SQ_BITS;
   localparam int AW  = (SQW > 2 * SB) ? SQW : 2 * SB;
   localparam int BW  = (SB > NW) ? SB : NW;
   localparam int PW  = AW + BW;
   localparam int QW  = SUMW + 1;
   localparam int MW  = SQW + 1;
   localparam int VW  = SQW + FRAC_BITS + 1;
   localparam int DW  = (VW > 2 * SB - 1) ? VW : 2 * SB - 1;
   localparam int LW  = $clog2(DW + 1);
   localparam int EW  = ((SUMW > SB + COUNT_BITS + 1) ? SUMW : SB + COUNT_BITS + 1) + 1;
   localparam int SCW = $clog2(RB + 1);
   localparam int OFS_N  = SB;
   localparam int OFS_M  = SB + NW;
   localparam int OFS_SE = 2 * SB + NW;

   localparam logic [PW-1:0]   ROUND_HALF = PW'((65'd1 << FRAC_BITS) >> 1);
   localparam logic [NW-1:0]   COUNT_MAX  = NW'(1) << COUNT_BITS;
   localparam logic [SQW-1:0]  SQ_MAX     = '1;
   localparam logic [SUMW-1:0] SUM_MAX    = {1'b0, {(SUMW - 1){1'b1}}};
   localparam logic [SUMW-1:0] SUM_MIN    = {1'b1, {(SUMW - 1){1'b0}}};
   localparam logic [QW-1:0]   MEAN_LIM   = QW'(1) << (SB - 1);
   localparam logic [RB-1:0]   SE_MAX     = '1;

   typedef enum logic [15:0] {
      S_IDLE     = 16'h0001,
      S_ADD      = 16'h0002,
      S_SQS      = 16'h0004,
      S_MERGE    = 16'h0008,
      S_MUL_MN   = 16'h0010,
      S_MUL_SE   = 16'h0020,
      S_MUL_SEN  = 16'h0040,
      S_MUL_MM   = 16'h0080,
      S_MUL_TN   = 16'h0100,
      S_STATS    = 16'h0200,
      S_DIV_MEAN = 16'h0400,
      S_DIV_MS   = 16'h0800,
      S_MUL_Q    = 16'h1000,
      S_DIV_VAR  = 16'h2000,
      S_SQRT     = 16'h4000,
      S_OUT      = 16'h8000
   } state_type;

   state_type              state_ff, state_in;
   logic                   start_ff, start_in;
   rmsa_pkg::cmd_type      req_cmd;

   logic [SB-1:0]          samp_ff, samp_in;
   logic [NW-1:0]          setn_ff, setn_in;
   logic [SB-1:0]          smean_ff, smean_in;
   logic [RB-1:0]          sse_ff, sse_in;

   logic [NW-1:0]          count_ff, count_in;
   logic signed [SUMW-1:0] sum_ff, sum_in;
   logic [SQW-1:0]         sq_ff, sq_in;
   logic                   ovf_ff, ovf_in;

   logic [AW-1:0]          tmp_ff, tmp_in;
   logic [SB-1:0]          q_ff, q_in;
   logic [SB-1:0]          mean_ff, mean_in;
   logic [SQW-1:0]         ms_ff, ms_in;
   logic                   sat_ff, sat_in;
   logic [2*RB-1:0]        rad_ff, rad_in;
   logic [RB-1:0]          root_ff, root_in;
   logic [RB:0]            srem_ff, srem_in;
   logic [SCW-1:0]         scnt_ff, scnt_in;
   logic [RB-1:0]          se_res_ff, se_res_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_BITS-1:0]    rsp_data_ff, rsp_data_in;
   logic [1:0]             rsp_user_ff, rsp_user_in;

   logic [SB-1:0]          samp_mag, smean_mag;
   logic [SUMW-1:0]        sum_mag;
   logic [NW-1:0]          half_n, n_eff;

   logic                   mul_start, mul_done;
   logic [AW-1:0]          mul_a;
   logic [BW-1:0]          mul_b;
   logic [PW-1:0]          mul_prod;
   logic [PW:0]            prod_rnd;
   logic [PW-1:0]          prod_q;
   logic                   prod_sat;
   logic [SQW-1:0]         prod_cap;

   logic                   div_start, div_done;
   logic [LW-1:0]          div_len;
   logic [DW-1:0]          div_dvd;
   logic [DW-1:0]          div_quot;

   logic [NW-1:0]          cnt_add;
   logic [NW:0]            cnt_t;
   logic                   cnt_ovf;
   logic [NW-1:0]          cnt_new;

   logic signed [EW-1:0]   sum_delta, sum_t, prod_signed;
   logic [EW-SUMW:0]       sum_top;
   logic                   sum_ovf;
   logic [SUMW-1:0]        sum_new;

   logic [AW-1:0]          sq_delta;
   logic [AW:0]            sq_t;
   logic                   sq_ovf;
   logic [AW:0]            t_sum;
   logic                   t_ovf;

   logic [QW-1:0]          mean_q, mean_lim, mean_qc;
   logic [PW-1:0]          ms_wide;

   logic [RB+2:0]          s_rem_w, s_trial, s_diff;
   logic                   s_ge;
   logic [RB-1:0]          root_new;

   assign req_cmd  = rmsa_pkg::cmd_type'(req_tuser);
   assign req_tready = (state_ff == S_IDLE);

   assign samp_mag  = samp_ff[SB-1] ? (~samp_ff + 1'b1) : samp_ff;
   assign smean_mag = smean_ff[SB-1] ? (~smean_ff + 1'b1) : smean_ff;
   assign sum_mag   = sum_ff[SUMW-1] ? SUMW'(~sum_ff + 1'b1) : SUMW'(sum_ff);
   assign half_n    = count_ff >> 1;
   assign n_eff     = (setn_ff > COUNT_MAX) ? COUNT_MAX : setn_ff;

   // product post-processing
   assign prod_rnd = (PW + 1)'(mul_prod) + (PW + 1)'(ROUND_HALF);
   assign prod_q   = PW'(prod_rnd >> FRAC_BITS);
   assign prod_sat = |mul_prod[PW-1:SQW];
   assign prod_cap = prod_sat ? SQ_MAX : mul_prod[SQW-1:0];

   // count adder
   assign cnt_add = (state_ff == S_ADD) ? NW'(1) : n_eff;
   assign cnt_t   = (NW + 1)'(count_ff) + (NW + 1)'(cnt_add);
   assign cnt_ovf = cnt_t > (NW + 1)'(COUNT_MAX);
   assign cnt_new = cnt_ovf ? COUNT_MAX : cnt_t[NW-1:0];

   // signed sum adder
   assign prod_signed = EW'($signed({1'b0, mul_prod[SB+COUNT_BITS-1:0]}));
   assign sum_delta   = (state_ff == S_ADD) ? EW'($signed(samp_ff))
                      : (smean_ff[SB-1] ? -prod_signed : prod_signed);
   assign sum_t   = EW'(sum_ff) + sum_delta;
   assign sum_top = sum_t[EW-1:SUMW-1];
   assign sum_ovf = (|sum_top) && !(&sum_top);
   assign sum_new = sum_ovf ? (sum_t[EW-1] ? SUM_MIN : SUM_MAX) : sum_t[SUMW-1:0];

   // square sum adder
   assign sq_delta = (state_ff == S_SQS) ? prod_q[AW-1:0] : AW'(prod_cap);
   assign sq_t     = (AW + 1)'(sq_ff) + (AW + 1)'(sq_delta);
   assign sq_ovf   = |sq_t[AW:SQW];

   // merge term: capped se^2*n plus rounded mean^2
   assign t_sum = (AW + 1)'(tmp_ff) + (AW + 1)'(prod_q[AW-1:0]);
   assign t_ovf = |t_sum[AW:SQW];

   // mean clamp
   assign mean_q   = div_quot[QW-1:0];
   assign mean_lim = sum_ff[SUMW-1] ? MEAN_LIM : MEAN_LIM - 1'b1;
   assign mean_qc  = (mean_q > mean_lim) ? mean_lim : mean_q;
   assign ms_wide  = PW'(ms_ff);

   // square root step, two radicand bits per cycle
   assign s_rem_w  = {srem_ff, rad_ff[2*RB-1 -: 2]};
   assign s_trial  = {1'b0, root_ff, 2'b01};
   assign s_ge     = s_rem_w >= s_trial;
   assign s_diff   = s_rem_w - s_trial;
   assign root_new = {root_ff[RB-2:0], s_ge};

   assign mul_start = start_ff && ((state_ff == S_SQS) || (state_ff == S_MUL_MN) ||
                      (state_ff == S_MUL_SE) || (state_ff == S_MUL_SEN) ||
                      (state_ff == S_MUL_MM) || (state_ff == S_MUL_TN) ||
                      (state_ff == S_MUL_Q));
   assign div_start = start_ff && ((state_ff == S_DIV_MEAN) || (state_ff == S_DIV_MS) ||
                      (state_ff == S_DIV_VAR));

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_SQS: begin
            mul_a = AW'(samp_mag);
            mul_b = BW'(samp_mag);
         end
         S_MUL_MN: begin
            mul_a = AW'(smean_mag);
            mul_b = BW'(setn_ff);
         end
         S_MUL_SE: begin
            mul_a = AW'(sse_ff);
            mul_b = BW'(sse_ff);
         end
         S_MUL_SEN: begin
            mul_a = tmp_ff;
            mul_b = BW'(setn_ff);
         end
         S_MUL_MM: begin
            mul_a = AW'(smean_mag);
            mul_b = BW'(smean_mag);
         end
         S_MUL_TN: begin
            mul_a = tmp_ff;
            mul_b = BW'(setn_ff);
         end
         S_MUL_Q: begin
            mul_a = AW'(q_ff);
            mul_b = BW'(q_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      div_len = '0;
      div_dvd = '0;
      case (state_ff)
         S_DIV_MEAN: begin
            div_len = LW'(QW);
            div_dvd = DW'(QW'(sum_mag) + QW'(half_n)) << (DW - QW);
         end
         S_DIV_MS: begin
            div_len = LW'(MW);
            div_dvd = DW'(MW'(sq_ff) + MW'(half_n)) << (DW - MW);
         end
         S_DIV_VAR: begin
            div_len = LW'(VW);
            div_dvd = DW'((VW'(ms_ff) << FRAC_BITS) + VW'(half_n)) << (DW - VW);
         end
         default: begin
            div_len = '0;
            div_dvd = '0;
         end
      endcase
   end

   rmsa_serial_mul #(
      .A_BITS (AW),
      .B_BITS (BW)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .product (mul_prod),
      .done    (mul_done)
   );

   rmsa_serial_div #(
      .DIVIDEND_BITS (DW),
      .DIVISOR_BITS  (NW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .len      (div_len),
      .dividend (div_dvd),
      .divisor  (count_ff),
      .quotient (div_quot),
      .done     (div_done)
   );

   always_comb begin
      state_in     = state_ff;
      start_in     = 1'b0;
      samp_in      = samp_ff;
      setn_in      = setn_ff;
      smean_in     = smean_ff;
      sse_in       = sse_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      sq_in        = sq_ff;
      ovf_in       = ovf_ff;
      tmp_in       = tmp_ff;
      q_in         = q_ff;
      mean_in      = mean_ff;
      ms_in        = ms_ff;
      sat_in       = sat_ff;
      rad_in       = rad_ff;
      root_in      = root_ff;
      srem_in      = srem_ff;
      scnt_in      = scnt_ff;
      se_res_in    = se_res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               samp_in  = req_tdata[SB-1:0];
               setn_in  = req_tdata[OFS_N +: NW];
               smean_in = req_tdata[OFS_M +: SB];
               sse_in   = req_tdata[OFS_SE +: RB];
               case (req_cmd)
                  rmsa_pkg::CMD_ADD: begin
                     state_in = S_ADD;
                  end
                  rmsa_pkg::CMD_MERGE: begin
                     state_in = S_MERGE;
                  end
                  rmsa_pkg::CMD_CLEAR: begin
                     count_in = '0;
                     sum_in   = '0;
                     sq_in    = '0;
                     ovf_in   = 1'b0;
                     state_in = S_STATS;
                  end
                  rmsa_pkg::CMD_REPLACE: begin
                     count_in = '0;
                     sum_in   = '0;
                     sq_in    = '0;
                     ovf_in   = 1'b0;
                     state_in = S_MERGE;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_ADD: begin
            count_in = cnt_new;
            sum_in   = signed'(sum_new);
            ovf_in   = ovf_ff | cnt_ovf | sum_ovf;
            start_in = 1'b1;
            state_in = S_SQS;
         end
         S_SQS: begin
            if (mul_done) begin
               sq_in    = sq_ovf ? SQ_MAX : sq_t[SQW-1:0];
               ovf_in   = ovf_ff | sq_ovf;
               state_in = S_STATS;
            end
         end
         S_MERGE: begin
            setn_in  = n_eff;
            count_in = cnt_new;
            ovf_in   = ovf_ff | (setn_ff > COUNT_MAX) | cnt_ovf;
            start_in = 1'b1;
            state_in = S_MUL_MN;
         end
         S_MUL_MN: begin
            if (mul_done) begin
               sum_in   = signed'(sum_new);
               ovf_in   = ovf_ff | sum_ovf;
               start_in = 1'b1;
               state_in = S_MUL_SE;
            end
         end
         S_MUL_SE: begin
            if (mul_done) begin
               tmp_in   = prod_q[AW-1:0];
               start_in = 1'b1;
               state_in = S_MUL_SEN;
            end
         end
         S_MUL_SEN: begin
            if (mul_done) begin
               tmp_in   = AW'(prod_cap);
               ovf_in   = ovf_ff | prod_sat;
               start_in = 1'b1;
               state_in = S_MUL_MM;
            end
         end
         S_MUL_MM: begin
            if (mul_done) begin
               tmp_in   = t_ovf ? AW'(SQ_MAX) : AW'(t_sum[SQW-1:0]);
               ovf_in   = ovf_ff | t_ovf;
               start_in = 1'b1;
               state_in = S_MUL_TN;
            end
         end
         S_MUL_TN: begin
            if (mul_done) begin
               sq_in    = sq_ovf ? SQ_MAX : sq_t[SQW-1:0];
               ovf_in   = ovf_ff | prod_sat | sq_ovf;
               state_in = S_STATS;
            end
         end
         S_STATS: begin
            if (count_ff == '0) begin
               mean_in   = '0;
               se_res_in = '0;
               state_in  = S_OUT;
            end else begin
               start_in = 1'b1;
               state_in = S_DIV_MEAN;
            end
         end
         S_DIV_MEAN: begin
            if (div_done) begin
               q_in     = mean_qc[SB-1:0];
               mean_in  = sum_ff[SUMW-1] ? (~mean_qc[SB-1:0] + 1'b1) : mean_qc[SB-1:0];
               start_in = 1'b1;
               state_in = S_DIV_MS;
            end
         end
         S_DIV_MS: begin
            if (div_done) begin
               ms_in    = div_quot[SQW-1:0];
               start_in = 1'b1;
               state_in = S_MUL_Q;
            end
         end
         S_MUL_Q: begin
            if (mul_done) begin
               ms_in    = (ms_wide > prod_q) ? SQW'(ms_wide - prod_q) : '0;
               start_in = 1'b1;
               state_in = S_DIV_VAR;
            end
         end
         S_DIV_VAR: begin
            if (div_done) begin
               sat_in   = |div_quot[DW-1:2*RB];
               rad_in   = div_quot[2*RB-1:0];
               root_in  = '0;
               srem_in  = '0;
               scnt_in  = SCW'(RB);
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            rad_in  = rad_ff << 2;
            root_in = root_new;
            srem_in = s_ge ? s_diff[RB:0] : s_rem_w[RB:0];
            scnt_in = scnt_ff - 1'b1;
            if (scnt_ff == SCW'(1)) begin
               se_res_in = sat_ff ? SE_MAX : root_new;
               state_in  = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_BITS'({se_res_ff, mean_ff, count_ff});
               rsp_user_in  = {ovf_ff, (count_ff == '0)};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         start_ff     <= 1'b0;
         count_ff     <= '0;
         sum_ff       <= '0;
         sq_ff        <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         sq_ff        <= sq_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      samp_ff     <= samp_in;
      setn_ff     <= setn_in;
      smean_ff    <= smean_in;
      sse_ff      <= sse_in;
      tmp_ff      <= tmp_in;
      q_ff        <= q_in;
      mean_ff     <= mean_in;
      ms_ff       <= ms_in;
      sat_ff      <= sat_in;
      rad_ff      <= rad_in;
      root_ff     <= root_in;
      srem_ff     <= srem_in;
      scnt_ff     <= scnt_in;
      se_res_ff   <= se_res_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

### rtl/core/rmsa_serial_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module rmsa_serial_mul #(
   parameter int A_BITS = 56,
   parameter int B_BITS = 24
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [A_BITS-1:0]          a,
   input  logic [B_BITS-1:0]          b,
   output logic [A_BITS+B_BITS-1:0]   product,
   output logic                       done
);

   localparam int P_BITS = A_BITS + B_BITS;
   localparam int C_BITS = $clog2(B_BITS + 1);

   logic [A_BITS-1:0] a_ff, a_in;
   logic [B_BITS-1:0] b_ff, b_in;
   logic [P_BITS-1:0] acc_ff, acc_in;
   logic [C_BITS-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [A_BITS:0]   part;

   assign part = {1'b0, acc_ff[P_BITS-1:B_BITS]} + (b_ff[0] ? {1'b0, a_ff} : '0);

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = a;
         b_in    = b;
         acc_in  = '0;
         cnt_in  = C_BITS'(B_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = {part, acc_ff[B_BITS-1:1]};
         b_in   = b_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == C_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
   end

   assign product = acc_ff;
   assign done    = done_ff;

endmodule

### rtl/core/rmsa_serial_div.sv
// Restoring divider, one quotient bit per cycle over a left-aligned dividend.
module rmsa_serial_div #(
   parameter  int DIVIDEND_BITS = 69,
   parameter  int DIVISOR_BITS  = 21,
   localparam int LEN_BITS      = $clog2(DIVIDEND_BITS + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [LEN_BITS-1:0]      len,
   input  logic [DIVIDEND_BITS-1:0] dividend,
   input  logic [DIVISOR_BITS-1:0]  divisor,
   output logic [DIVIDEND_BITS-1:0] quotient,
   output logic                     done
);

   localparam int DW = DIVIDEND_BITS;
   localparam int NW = DIVISOR_BITS;

   logic [DW-1:0]       num_ff, num_in;
   logic [DW-1:0]       quot_ff, quot_in;
   logic [NW-1:0]       den_ff, den_in;
   logic [NW-1:0]       rem_ff, rem_in;
   logic [LEN_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [NW:0]         rem_w;
   logic [NW+1:0]       diff;
   logic                fits;

   assign rem_w = {rem_ff, num_ff[DW-1]};
   assign diff  = {1'b0, rem_w} - {2'b00, den_ff};
   assign fits  = !diff[NW+1];

   always_comb begin
      num_in  = num_ff;
      quot_in = quot_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = dividend;
         den_in  = divisor;
         rem_in  = '0;
         quot_in = '0;
         cnt_in  = len;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in  = num_ff << 1;
         rem_in  = fits ? diff[NW-1:0] : rem_w[NW-1:0];
         quot_in = {quot_ff[DW-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == LEN_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      quot_ff <= quot_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
   end

   assign quotient = quot_ff;
   assign done     = done_ff;

endmodule
